[design/line_position_pid_steering_top_macros.svh]
// Assertion macros for the line position PID steering block.
// Used by the top level; expects clk and rst_n in scope.
`ifndef LINE_POSITION_PID_STEERING_TOP_MACROS_SVH
`define LINE_POSITION_PID_STEERING_TOP_MACROS_SVH

// Same-cycle implication, disabled in reset
`define LPS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset
`define LPS_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/lps_pkg.sv]
// Shared constants, types and register indexes for the line position
// PID steering block. No dependencies.
package lps_pkg;

    // field widths fixed by the item format
    localparam int SAMPLE_W        = 10;
    localparam int MAX_SENSORS     = 8;
    localparam int NUM_SENSORS_DEF = 8;
    localparam int SAMPLE_BITS_DEF = 10;
    localparam int POS_STEP        = 1000;
    localparam int POS_W           = 13;
    localparam int WPROD_W         = 23;
    localparam int WSUM_W          = 26;
    localparam int SUM_W           = 13;
    localparam int PWM_TOP         = 250;
    localparam int IN_DATA_W       = MAX_SENSORS * SAMPLE_W;
    localparam int OUT_DATA_W      = 32;

    // shared divider
    localparam int NUM_W  = 48;
    localparam int DEN_W  = 24;
    localparam int QUO_W  = 13;
    localparam int ITER_W = 4;
    localparam logic [ITER_W-1:0] CDIV_ITERS = ITER_W'(QUO_W);
    localparam logic [ITER_W-1:0] PDIV_ITERS = ITER_W'(8);

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_NOISE_THR  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DETECT_THR = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KP_DIV     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KI_DIV     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_KD_GAIN    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_SPEED = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_DIFF   = 3'd6;

    // per-lane findings
    typedef struct packed {
        logic                noise_hit;
        logic                detect_hit;
        logic [SAMPLE_W-1:0] value;
        logic [WPROD_W-1:0]  weighted;
    } lane_res_t;

    // merged findings over all lanes
    typedef struct packed {
        logic              seen;
        logic [WSUM_W-1:0] wsum;
        logic [SUM_W-1:0]  sum;
    } merge_res_t;

    // divider request
    typedef struct packed {
        logic              start;
        logic [ITER_W-1:0] iters;
    } div_req_t;

endpackage

[design/lps_lane.sv]
// One sensor lane: threshold tests and weighted sample.
// Depends on lps_pkg.
module lps_lane
    import lps_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int LANE_IDX    = 0
)
(
    input  logic [SAMPLE_W-1:0] sample,
    input  logic [SAMPLE_W-1:0] noise_thr,
    input  logic [SAMPLE_W-1:0] detect_thr,
    output lane_res_t           res
);

    localparam logic [SAMPLE_W-1:0] MASK = (SAMPLE_BITS >= SAMPLE_W) ? {SAMPLE_W{1'b1}}
                                         : SAMPLE_W'((1 << SAMPLE_BITS) - 1);
    localparam logic [POS_W-1:0] WEIGHT = POS_W'(LANE_IDX * POS_STEP);

    logic [SAMPLE_W-1:0] v;
    logic [WPROD_W-1:0]  prod;

    assign v    = sample & MASK;
    assign prod = WPROD_W'(v) * WPROD_W'(WEIGHT);

    // only samples above the noise floor join the centroid
    always_comb
    begin
        res.detect_hit = (v > detect_thr);
        res.noise_hit  = (v > noise_thr);
        res.value      = res.noise_hit ? v : '0;
        res.weighted   = res.noise_hit ? prod : '0;
    end

endmodule

[design/lps_merge.sv]
// Merging stage: sums lane results into weighted and plain sums and a line-seen flag.
// Depends on lps_pkg.
module lps_merge
    import lps_pkg::*;
#(
    parameter int NUM_SENSORS = NUM_SENSORS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       load,
    input  lane_res_t  lane_res [NUM_SENSORS],
    output merge_res_t merged
);

    merge_res_t merged_reg;
    merge_res_t merged_next;

    // sum across lanes
    always_comb
    begin
        merged_next = '0;
        for (int i = 0; i < NUM_SENSORS; i++)
        begin
            merged_next.seen = merged_next.seen | lane_res[i].detect_hit;
            merged_next.wsum = merged_next.wsum + WSUM_W'(lane_res[i].weighted);
            merged_next.sum  = merged_next.sum + SUM_W'(lane_res[i].value);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            merged_reg <= '0;
        end
        else if (load)
        begin
            merged_reg <= merged_next;
        end
    end

    assign merged = merged_reg;

endmodule

[design/lps_div.sv]
// Restoring divider, one quotient bit per cycle, shared by the
// centroid and the steering term. Depends on lps_pkg.
module lps_div
    import lps_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  div_req_t         req,
    input  logic [NUM_W-1:0] dividend,
    input  logic [DEN_W-1:0] divisor,
    output logic [QUO_W-1:0] quotient,
    output logic             done
);

    logic [NUM_W-1:0]  rem_reg, rem_next;
    logic [NUM_W-1:0]  dsh_reg, dsh_next;
    logic [QUO_W-1:0]  q_reg, q_next;
    logic [ITER_W-1:0] cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    // one trial subtraction per cycle
    always_comb
    begin
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            rem_next  = dividend;
            dsh_next  = NUM_W'(divisor) << (req.iters - ITER_W'(1));
            q_next    = '0;
            cnt_next  = req.iters;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (rem_reg >= dsh_reg)
            begin
                rem_next = rem_reg - dsh_reg;
                q_next   = {q_reg[QUO_W-2:0], 1'b1};
            end
            else
            begin
                q_next = {q_reg[QUO_W-2:0], 1'b0};
            end
            dsh_next = dsh_reg >> 1;
            cnt_next = cnt_reg - ITER_W'(1);
            if (cnt_reg == ITER_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        q_reg   <= q_next;
    end

    assign quotient = q_reg;
    assign done     = done_reg;

endmodule

[design/line_position_pid_steering_top.sv]
// Line follower steering: sensor lanes, merge, shared divider and PID sequencer.
// Depends on lps_pkg, lps_lane, lps_merge, lps_div and the macros header.
//
// Usage:
//   Input stream s_*: one item carries eight 10-bit reflectance samples,
//   sample_0 in the lowest bits. Output stream m_*: one item per input with
//   line position, line-seen flag, wheel duties and reverse flags.
//   Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; write
//   only while the block is idle. cfg_ready is always high.
// Sequence:
//   From accept to m_tvalid the item passes the sum and position states, a
//   centroid division when the line is seen and the sample sum is nonzero,
//   the seven-step multiply sequence and a compare, a steering division on
//   the shared restoring divider unless the steering term clamps, and the
//   output state. One item is in work at a time; the next is taken the
//   cycle after the previous result enters the output register.
// Reset: configuration registers return to defaults, PID state and last position cleared.
// Stall: a result waits in the output register while m_tready is low; the
//   block can take and work a new item but holds it before output.
`include "line_position_pid_steering_top_macros.svh"
module line_position_pid_steering_top
    import lps_pkg::*;
#(
    parameter int NUM_SENSORS = NUM_SENSORS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // sample_0 .. sample_7, 10 bits each, from the lowest bit up
    input  logic [IN_DATA_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // line_position[12:0], line_seen[13], left_duty[21:14],
    // right_duty[29:22], left_reverse[30], right_reverse[31]
    output logic [OUT_DATA_W-1:0] m_tdata,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam logic [POS_W-1:0] SPAN   = POS_W'((NUM_SENSORS - 1) * POS_STEP);
    localparam logic [POS_W-1:0] CENTRE = POS_W'(((NUM_SENSORS - 1) * POS_STEP) / 2);

    // multiply sequence steps
    localparam logic [2:0] ST_KPKI = 3'd0;
    localparam logic [2:0] ST_M1   = 3'd1;
    localparam logic [2:0] ST_M2   = 3'd2;
    localparam logic [2:0] ST_M3   = 3'd3;
    localparam logic [2:0] ST_M4   = 3'd4;
    localparam logic [2:0] ST_NUM  = 3'd5;
    localparam logic [2:0] ST_MAG  = 3'd6;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_SUM  = 8'b0000_0010,
        S_POS  = 8'b0000_0100,
        S_CDIV = 8'b0000_1000,
        S_MUL  = 8'b0001_0000,
        S_CMP  = 8'b0010_0000,
        S_PDIV = 8'b0100_0000,
        S_OUT  = 8'b1000_0000
    } state_t;

    state_t state_reg;

    // configuration registers
    logic [SAMPLE_W-1:0] noise_thr_reg, detect_thr_reg;
    logic [7:0]          kp_reg, kd_reg, bs_reg, md_reg;
    logic [15:0]         ki_reg;

    // work registers
    logic [IN_DATA_W-1:0] samp_reg;
    logic [POS_W-1:0]     pos_reg, last_pos_reg;
    logic                 seen_reg;
    logic [2:0]           step_reg;
    logic signed [13:0]   err_reg, prev_err_reg;
    logic signed [14:0]   der_reg;
    logic signed [31:0]   esum_reg;
    logic [DEN_W-1:0]     kpki_reg;
    logic signed [47:0]   m1_reg, m2_reg, m4_reg, num_reg;
    logic signed [23:0]   m3_reg;
    logic [31:0]          bsd_reg;
    logic [NUM_W-1:0]     mag_reg;
    logic                 neg_reg;
    logic [7:0]           term_mag_reg;

    // output registers
    logic                 m_valid_reg;
    logic [POS_W-1:0]     out_pos_reg;
    logic                 out_seen_reg;
    logic [7:0]           left_duty_reg, right_duty_reg;
    logic                 left_rev_reg, right_rev_reg;

    // lanes and merge
    lane_res_t  lane_res [NUM_SENSORS];
    merge_res_t merged;

    for (genvar g = 0; g < NUM_SENSORS; g++)
    begin : g_lane
        lps_lane #(
            .SAMPLE_BITS (SAMPLE_BITS),
            .LANE_IDX    (g)
        ) u_lane (
            .sample     (samp_reg[g*SAMPLE_W +: SAMPLE_W]),
            .noise_thr  (noise_thr_reg),
            .detect_thr (detect_thr_reg),
            .res        (lane_res[g])
        );
    end

    lps_merge #(
        .NUM_SENSORS (NUM_SENSORS)
    ) u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (state_reg == S_SUM),
        .lane_res (lane_res),
        .merged   (merged)
    );

    // shared divider
    div_req_t         div_req;
    logic [NUM_W-1:0] div_num;
    logic [DEN_W-1:0] div_den;
    logic [QUO_W-1:0] div_quo;
    logic             div_done;
    logic             cdiv_go, pdiv_go;

    assign cdiv_go = (state_reg == S_POS) && merged.seen && (merged.sum != '0);
    assign pdiv_go = (state_reg == S_CMP) && ({16'd0, bsd_reg} > mag_reg);

    always_comb
    begin
        div_req.start = cdiv_go || pdiv_go;
        div_req.iters = cdiv_go ? CDIV_ITERS : PDIV_ITERS;
        div_num       = cdiv_go ? NUM_W'(merged.wsum) : mag_reg;
        div_den       = cdiv_go ? DEN_W'(merged.sum) : kpki_reg;
    end

    lps_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .dividend (div_num),
        .divisor  (div_den),
        .quotient (div_quo),
        .done     (div_done)
    );

    // effective divisors, zero acts as one
    logic [7:0]  kp_eff;
    logic [15:0] ki_eff;
    assign kp_eff = (kp_reg == 8'd0) ? 8'd1 : kp_reg;
    assign ki_eff = (ki_reg == 16'd0) ? 16'd1 : ki_reg;

    // products, one used per step
    logic signed [30:0] m1_full;
    logic signed [40:0] m2_full;
    logic signed [23:0] m3_full;
    logic signed [48:0] m4_full;
    logic [31:0]        bsd_full;
    logic signed [32:0] acc_full;

    assign m1_full  = err_reg * $signed({1'b0, ki_eff});
    assign m2_full  = esum_reg * $signed({1'b0, kp_eff});
    assign m3_full  = der_reg * $signed({1'b0, kd_reg});
    assign m4_full  = m3_reg * $signed({1'b0, kpki_reg});
    assign bsd_full = 32'(bs_reg) * 32'(kpki_reg);
    assign acc_full = 33'(esum_reg) + 33'(err_reg);

    // wheel split and skid limit
    logic signed [9:0] bs10, md10, mag10, left_s, right_s, diff_s, left_f, right_f;
    logic [7:0]        left_duty, right_duty;

    always_comb
    begin
        bs10   = $signed({2'b00, bs_reg});
        md10   = $signed({2'b00, md_reg});
        mag10  = $signed({2'b00, term_mag_reg});
        left_s  = neg_reg ? (bs10 - mag10) : bs10;
        right_s = neg_reg ? bs10 : (bs10 - mag10);
        diff_s  = left_s - right_s;
        left_f  = left_s;
        right_f = right_s;
        if (diff_s > md10)
        begin
            left_f = left_s - (diff_s >>> 1);
        end
        else if ((-diff_s) > md10)
        begin
            right_f = right_s - ((-diff_s) >>> 1);
        end
        left_duty  = left_f[9] ? 8'(10'(PWM_TOP) + left_f) : left_f[7:0];
        right_duty = right_f[9] ? 8'(10'(PWM_TOP) + right_f) : right_f[7:0];
    end

    // configuration writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            noise_thr_reg  <= 10'd50;
            detect_thr_reg <= 10'd200;
            kp_reg         <= 8'd3;
            ki_reg         <= 16'd50000;
            kd_reg         <= 8'd16;
            bs_reg         <= 8'd200;
            md_reg         <= 8'd20;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_NOISE_THR:  noise_thr_reg  <= cfg_data[SAMPLE_W-1:0];
                REG_DETECT_THR: detect_thr_reg <= cfg_data[SAMPLE_W-1:0];
                REG_KP_DIV:     kp_reg         <= cfg_data[7:0];
                REG_KI_DIV:     ki_reg         <= cfg_data;
                REG_KD_GAIN:    kd_reg         <= cfg_data[7:0];
                REG_BASE_SPEED: bs_reg         <= cfg_data[7:0];
                REG_MAX_DIFF:   md_reg         <= cfg_data[7:0];
                default:        ;
            endcase
        end
    end

    // sequencer and PID state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            step_reg     <= ST_KPKI;
            last_pos_reg <= '0;
            prev_err_reg <= '0;
            esum_reg     <= '0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            // result taken; in S_OUT a new result may replace it instead
            if (m_valid_reg && m_tready && (state_reg != S_OUT))
            begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        state_reg <= S_SUM;
                    end
                end
                S_SUM:
                begin
                    state_reg <= S_POS;
                end
                S_POS:
                begin
                    step_reg <= ST_KPKI;
                    if (cdiv_go)
                    begin
                        state_reg <= S_CDIV;
                    end
                    else
                    begin
                        state_reg <= S_MUL;
                    end
                end
                S_CDIV:
                begin
                    if (div_done)
                    begin
                        last_pos_reg <= div_quo;
                        state_reg    <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    step_reg <= step_reg + 3'd1;
                    if (step_reg == ST_MAG)
                    begin
                        prev_err_reg <= err_reg;
                        if (acc_full > 33'sd2147483647)
                        begin
                            esum_reg <= 32'sh7FFF_FFFF;
                        end
                        else if (acc_full < -33'sd2147483648)
                        begin
                            esum_reg <= 32'sh8000_0000;
                        end
                        else
                        begin
                            esum_reg <= acc_full[31:0];
                        end
                        state_reg <= S_CMP;
                    end
                end
                S_CMP:
                begin
                    state_reg <= pdiv_go ? S_PDIV : S_OUT;
                end
                S_PDIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (!m_valid_reg || m_tready)
                    begin
                        m_valid_reg <= 1'b1;
                        state_reg   <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            samp_reg <= s_tdata;
        end
        if (state_reg == S_POS)
        begin
            seen_reg <= merged.seen;
            if (!merged.seen)
            begin
                pos_reg <= (last_pos_reg < CENTRE) ? '0 : SPAN;
            end
            else
            begin
                pos_reg <= last_pos_reg;
            end
        end
        if ((state_reg == S_CDIV) && div_done)
        begin
            pos_reg <= div_quo;
        end
        if (state_reg == S_MUL)
        begin
            case (step_reg)
                ST_KPKI:
                begin
                    kpki_reg <= DEN_W'(kp_eff) * DEN_W'(ki_eff);
                    err_reg  <= $signed({1'b0, pos_reg}) - $signed({1'b0, CENTRE});
                end
                ST_M1:
                begin
                    m1_reg  <= 48'(m1_full);
                    der_reg <= 15'(err_reg) - 15'(prev_err_reg);
                end
                ST_M2:   m2_reg <= 48'(m2_full);
                ST_M3:   m3_reg <= m3_full;
                ST_M4:
                begin
                    m4_reg <= m4_full[47:0];
                    m1_reg <= m1_reg + m2_reg;
                end
                ST_NUM:
                begin
                    num_reg <= m1_reg + m4_reg;
                    bsd_reg <= bsd_full;
                end
                ST_MAG:
                begin
                    neg_reg <= num_reg[47];
                    mag_reg <= num_reg[47] ? NUM_W'(-num_reg) : NUM_W'(num_reg);
                end
                default: ;
            endcase
        end
        if ((state_reg == S_CMP) && !pdiv_go)
        begin
            term_mag_reg <= bs_reg;
        end
        if ((state_reg == S_PDIV) && div_done)
        begin
            term_mag_reg <= div_quo[7:0];
        end
        if ((state_reg == S_OUT) && (!m_valid_reg || m_tready))
        begin
            out_pos_reg    <= pos_reg;
            out_seen_reg   <= seen_reg;
            left_duty_reg  <= left_duty;
            right_duty_reg <= right_duty;
            left_rev_reg   <= left_f[9];
            right_rev_reg  <= right_f[9];
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {right_rev_reg, left_rev_reg, right_duty_reg, left_duty_reg,
                       out_seen_reg, out_pos_reg};

    // checks
    `LPS_ASSERT_IMP(a_busy_blocks_input, state_reg != S_IDLE, !s_tready, "input taken while busy")
    `LPS_ASSERT_NXT(a_accept_starts_sum, s_tvalid && s_tready, state_reg == S_SUM, "accept did not start work")
    `LPS_ASSERT_IMP(a_pos_in_span, m_valid_reg, out_pos_reg <= SPAN, "position beyond span")
    `LPS_ASSERT_IMP(a_no_reverse, m_valid_reg, !left_rev_reg && !right_rev_reg, "clamped speed went negative")

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench for line_position_pid_steering_top: centroid, line-lost
// and PID steering results are predicted in-bench and compared per item.
// Depends on lps_pkg and the design sources.
module testbench;
    import lps_pkg::*;

    localparam int CENTRE    = 3500;
    localparam int SPAN      = 7000;
    localparam int CYCLE_CAP = 600000;
    localparam int SETTLE    = 60;

    // expected result fields
    typedef struct packed {
        logic [POS_W-1:0] position;
        logic             seen;
        logic [7:0]       left_duty;
        logic [7:0]       right_duty;
        logic             left_rev;
        logic             right_rev;
    } steer_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // steering shadow state and registers
    int     noise_thr, detect_thr, kp_div, ki_div, kd_gain, base_speed, max_diff;
    int     last_pos, prev_err, err_sum;
    steer_t steer_queue[$];
    int     idle_pct, stall_pct;
    int     errors;
    int     cycles;

    line_position_pid_steering_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // work out one steering result and advance the shadow state
    function automatic steer_t steer_predict(logic [IN_DATA_W-1:0] d);
        steer_t r;
        longint wsum, sum, err, der, kp, ki, num, term, bs, acc;
        longint left, right;
        int     pos;
        int     v;
        logic   seen;
        wsum = 0;
        sum  = 0;
        seen = 1'b0;
        for (int i = 0; i < MAX_SENSORS; i++)
        begin
            v = d[i*SAMPLE_W +: SAMPLE_W];
            if (v > detect_thr) seen = 1'b1;
            if (v > noise_thr)
            begin
                wsum += longint'(v) * i * POS_STEP;
                sum  += v;
            end
        end
        if (!seen)
            pos = (last_pos < CENTRE) ? 0 : SPAN;
        else if (sum == 0)
            pos = last_pos;
        else
        begin
            pos = int'(wsum / sum);
            last_pos = pos;
        end
        err  = pos - CENTRE;
        der  = err - prev_err;
        kp   = (kp_div == 0) ? 1 : kp_div;
        ki   = (ki_div == 0) ? 1 : ki_div;
        num  = err * ki + longint'(err_sum) * kp + der * kd_gain * kp * ki;
        term = num / (kp * ki);
        bs   = base_speed;
        acc  = longint'(err_sum) + err;
        prev_err = int'(err);
        if (acc > 64'sd2147483647) acc = 64'sd2147483647;
        if (acc < -64'sd2147483648) acc = -64'sd2147483648;
        err_sum = int'(acc);
        if (term > bs) term = bs;
        if (term < -bs) term = -bs;
        if (term < 0)
        begin
            left  = bs + term;
            right = bs;
        end
        else
        begin
            left  = bs;
            right = bs - term;
        end
        // skid limit: pull the faster wheel halfway back
        if (left - right > max_diff)
            left -= (left - right) / 2;
        else if (right - left > max_diff)
            right -= (right - left) / 2;
        r.position   = POS_W'(pos);
        r.seen       = seen;
        r.left_rev   = (left < 0);
        r.right_rev  = (right < 0);
        r.left_duty  = (left < 0) ? 8'(PWM_TOP + left) : 8'(left);
        r.right_duty = (right < 0) ? 8'(PWM_TOP + right) : 8'(right);
        return r;
    endfunction

    // result checker and receiver stall
    always @(posedge clk)
    begin
        steer_t want;
        if (m_tvalid && m_tready)
        begin
            if (steer_queue.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result item %h", m_tdata);
            end
            else
            begin
                want = steer_queue.pop_front();
                if (m_tdata[12:0] !== want.position || m_tdata[13] !== want.seen ||
                    m_tdata[21:14] !== want.left_duty ||
                    m_tdata[29:22] !== want.right_duty ||
                    m_tdata[30] !== want.left_rev || m_tdata[31] !== want.right_rev)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: exp pos %0d seen %0d l %0d r %0d lr %0d rr %0d",
                                 want.position, want.seen, want.left_duty,
                                 want.right_duty, want.left_rev, want.right_rev,
                                 " | got pos %0d seen %0d l %0d r %0d lr %0d rr %0d",
                                 m_tdata[12:0], m_tdata[13], m_tdata[21:14],
                                 m_tdata[29:22], m_tdata[30], m_tdata[31]);
                end
            end
        end
        if (rst_n)
            m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // send one item and record its expected result
    task automatic send_samples(logic [IN_DATA_W-1:0] d);
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        steer_queue.push_back(steer_predict(d));
        while ($urandom_range(99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic stop_sending();
        s_tvalid <= 1'b0;
        @(posedge clk);
    endtask

    // wait until every result is back and the block has settled
    task automatic drain();
        stop_sending();
        while (steer_queue.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(val);
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (idx)
            REG_NOISE_THR:  noise_thr  = val & 'h3FF;
            REG_DETECT_THR: detect_thr = val & 'h3FF;
            REG_KP_DIV:     kp_div     = val & 'hFF;
            REG_KI_DIV:     ki_div     = val & 'hFFFF;
            REG_KD_GAIN:    kd_gain    = val & 'hFF;
            REG_BASE_SPEED: base_speed = val & 'hFF;
            REG_MAX_DIFF:   max_diff   = val & 'hFF;
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_all(int nt, int dt, int kp, int ki, int kd, int bs, int md);
        write_reg(REG_NOISE_THR, nt);
        write_reg(REG_DETECT_THR, dt);
        write_reg(REG_KP_DIV, kp);
        write_reg(REG_KI_DIV, ki);
        write_reg(REG_KD_GAIN, kd);
        write_reg(REG_BASE_SPEED, bs);
        write_reg(REG_MAX_DIFF, md);
    endtask

    // mostly line-shaped frames, some lost-line frames, some raw noise
    function automatic logic [IN_DATA_W-1:0] random_frame();
        logic [IN_DATA_W-1:0] d;
        int mode, peak, top, gap, v;
        mode = $urandom_range(9);
        peak = $urandom_range(7);
        top  = $urandom_range(1023, 250);
        for (int i = 0; i < MAX_SENSORS; i++)
        begin
            gap = (i > peak) ? i - peak : peak - i;
            if (mode < 2)
                v = $urandom_range(1023);
            else if (mode < 3)
                v = $urandom_range(180);
            else if (gap == 0)
                v = top;
            else if (gap == 1)
                v = $urandom_range(top);
            else
                v = $urandom_range(60);
            d[i*SAMPLE_W +: SAMPLE_W] = SAMPLE_W'(v);
        end
        return d;
    endfunction

    task automatic run_random(int n, int idle, int stall);
        idle_pct  = idle;
        stall_pct = stall;
        for (int k = 0; k < n; k++) send_samples(random_frame());
    endtask

    // field extremes, each sensor alone, line lost on either side
    task automatic test_directed();
        logic [IN_DATA_W-1:0] d;
        idle_pct  = 0;
        stall_pct = 0;
        send_samples('0);
        send_samples({MAX_SENSORS{10'h3FF}});
        for (int i = 0; i < MAX_SENSORS; i++)
        begin
            d = '0;
            d[i*SAMPLE_W +: SAMPLE_W] = 10'h3FF;
            send_samples(d);
        end
        // lost after the line was on the right
        send_samples('0);
        d = '0;
        d[0 +: SAMPLE_W] = 10'd201;
        send_samples(d);
        send_samples('0);
        drain();
    endtask

    // line seen but nothing above the noise floor, with one frame that has a sensor above it, then random frames
    task automatic test_seen_not_averaged();
        logic [IN_DATA_W-1:0] d;
        write_reg(REG_NOISE_THR, 900);
        write_reg(REG_DETECT_THR, 100);
        d = {MAX_SENSORS{10'd500}};
        send_samples(d);
        d[3*SAMPLE_W +: SAMPLE_W] = 10'd950;
        send_samples(d);
        send_samples({MAX_SENSORS{10'd500}});
        run_random(15, 0, 0);
        drain();
    endtask

    // register sweep over extremes, zero divisors and full speed
    task automatic test_register_sweep();
        write_all(0, 0, 0, 0, 255, 255, 0);
        run_random(25, 20, 20);
        drain();
        write_all(1023, 1023, 1, 1, 0, 0, 250);
        run_random(20, 20, 20);
        drain();
        write_all(30, 300, 255, 65535, 1, 250, 250);
        run_random(25, 20, 20);
        drain();
        write_all(120, 150, 7, 1000, 40, 120, 5);
        run_random(25, 20, 20);
        drain();
        write_all(50, 200, 3, 50000, 16, 200, 20);
    endtask

    // idle and stall phases on the default settings
    task automatic test_flow_control();
        run_random(100, 0, 0);
        run_random(100, 62, 0);
        run_random(100, 0, 62);
        run_random(100, 6, 6);
        drain();
    endtask

    initial
    begin
        errors = 0;
        cycles = 0;
        idle_pct = 0;
        stall_pct = 0;
        noise_thr = 50;
        detect_thr = 200;
        kp_div = 3;
        ki_div = 50000;
        kd_gain = 16;
        base_speed = 200;
        max_diff = 20;
        last_pos = 0;
        prev_err = 0;
        err_sum = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_seen_not_averaged();
        test_register_sweep();
        test_flow_control();
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
